FILE: design/sir_lattice_monte_carlo_update_core_macros.svh
// Assertion macros shared by the checker of the SIR lattice update core.
// No dependencies; include by bare file name.
`ifndef SIR_LATTICE_MONTE_CARLO_UPDATE_CORE_MACROS_SVH
`define SIR_LATTICE_MONTE_CARLO_UPDATE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SIRL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sirl assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SIRL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sirl assertion failed");

// Next-cycle implication that also holds across reset.
`define SIRL_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sirl assertion failed");

`endif

FILE: design/sirl_pkg.sv
// Shared types, widths and codes for the SIR lattice update core.
// No dependencies; every other design file but the macros header imports it.
package sirl_pkg;

   localparam int ROWS_DEFAULT = 128;
   localparam int COLS_DEFAULT = 128;

   localparam int ROW_W   = 7;
   localparam int COL_W   = 7;
   localparam int DIR_W   = 2;
   localparam int DRAW_W  = 16;
   localparam int THR_W   = 17;
   localparam int COUNT_W = 15;
   localparam int CHG_W   = 2;
   localparam int CELL_W  = 2;

   localparam logic [THR_W-1:0] THR_RESET = 17'd53084;

   // cell states
   localparam logic [CELL_W-1:0] CELL_SUS = 2'd0;
   localparam logic [CELL_W-1:0] CELL_INF = 2'd1;
   localparam logic [CELL_W-1:0] CELL_REC = 2'd2;

   // neighbor directions
   localparam logic [DIR_W-1:0] DIR_ROW_INC = 2'd0;
   localparam logic [DIR_W-1:0] DIR_ROW_DEC = 2'd1;
   localparam logic [DIR_W-1:0] DIR_COL_INC = 2'd2;
   localparam logic [DIR_W-1:0] DIR_COL_DEC = 2'd3;

   // change codes
   localparam logic [CHG_W-1:0] CHG_NONE    = 2'd0;
   localparam logic [CHG_W-1:0] CHG_INFECT  = 2'd1;
   localparam logic [CHG_W-1:0] CHG_RECOVER = 2'd2;

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [DIR_W-1:0]  direction;
      logic [DRAW_W-1:0] action_draw;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0] susceptible_count;
      logic [COUNT_W-1:0] infected_count;
      logic [COUNT_W-1:0] recovered_count;
      logic [CHG_W-1:0]   cell_changed;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic clear;     // write one entry of the clearing pass
      logic load;      // capture a new transaction
      logic rd_act;    // read the chosen cell
      logic rd_pas;    // read the neighbor cell
      logic cap_act;   // hold the chosen cell state
      logic exec;      // decide, write back, load the result register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
   } dp_status_type;

endpackage

FILE: design/sirl_req_if.sv
// Request channel: one Monte Carlo trial per transaction.
// Depends on sirl_pkg.
interface sirl_req_if;
   import sirl_pkg::*;

   logic              valid;
   logic              ready;
   logic [ROW_W-1:0]  row;
   logic [COL_W-1:0]  col;
   logic [DIR_W-1:0]  direction;
   logic [DRAW_W-1:0] action_draw;

   modport source (output valid, output row, output col, output direction,
                   output action_draw, input ready);
   modport sink   (input valid, input row, input col, input direction,
                   input action_draw, output ready);
endinterface

FILE: design/sirl_rsp_if.sv
// Response channel: running class counts and change code per trial.
// Depends on sirl_pkg.
interface sirl_rsp_if;
   import sirl_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] susceptible_count;
   logic [COUNT_W-1:0] infected_count;
   logic [COUNT_W-1:0] recovered_count;
   logic [CHG_W-1:0]   cell_changed;

   modport source (output valid, output susceptible_count, output infected_count,
                   output recovered_count, output cell_changed, input ready);
   modport sink   (input valid, input susceptible_count, input infected_count,
                   input recovered_count, input cell_changed, output ready);
endinterface

FILE: design/sirl_ctrl.sv
// Sequencer of the SIR lattice update core: clearing pass, reads, execute.
// Depends on sirl_pkg.
module sirl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  sirl_pkg::dp_status_type status,
   output sirl_pkg::ctrl_cmd_type  cmd
);
   import sirl_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_RD_ACT = 3'd2;
   localparam logic [2:0] ST_RD_PAS = 3'd3;
   localparam logic [2:0] ST_EXEC   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       exec_fire;
   logic       accept;

   // execute only once the result register is free or being emptied
   assign exec_fire = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE) || exec_fire;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_RD_ACT;
         end
         ST_RD_ACT: state_in = ST_RD_PAS;
         ST_RD_PAS: state_in = ST_EXEC;
         ST_EXEC: begin
            if (exec_fire) state_in = accept ? ST_RD_ACT : ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_comb begin
      cmd         = '0;
      cmd.clear   = (state_ff == ST_CLEAR);
      cmd.load    = accept;
      cmd.rd_act  = (state_ff == ST_RD_ACT);
      cmd.rd_pas  = (state_ff == ST_RD_PAS);
      cmd.cap_act = (state_ff == ST_RD_PAS);
      cmd.exec    = exec_fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: design/sirl_dpath.sv
// Datapath of the SIR lattice update core: lattice memory, addressing,
// class counters, threshold register and result register. Depends on sirl_pkg.
module sirl_dpath #(
   parameter int ROWS = sirl_pkg::ROWS_DEFAULT,
   parameter int COLS = sirl_pkg::COLS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sirl_pkg::ctrl_cmd_type          cmd,
   output sirl_pkg::dp_status_type         status,
   input  sirl_pkg::req_payload_type       req_data,
   output sirl_pkg::rsp_payload_type       rsp_data,
   input  logic                            csr_wr_en,
   input  logic [sirl_pkg::THR_W-1:0]      csr_wr_data
);
   import sirl_pkg::*;

   localparam int RW     = $clog2(ROWS);
   localparam int CW     = $clog2(COLS);
   localparam int DEPTH  = ROWS * COLS;
   localparam int AW     = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] CENTRE = AW'((ROWS / 2) * COLS + (COLS / 2));
   localparam logic [AW-1:0] LAST   = AW'(DEPTH - 1);

   // reduce the fixed-width row and column modulo the lattice size
   logic [RW-1:0] row_mod [2**ROW_W];
   logic [CW-1:0] col_mod [2**COL_W];

   for (genvar k = 0; k < 2**ROW_W; k++) begin : g_row_mod
      assign row_mod[k] = RW'(k % ROWS);
   end
   for (genvar k = 0; k < 2**COL_W; k++) begin : g_col_mod
      assign col_mod[k] = CW'(k % COLS);
   end

   logic [CELL_W-1:0] lattice_ff [DEPTH];
   logic [CELL_W-1:0] mem_rd_ff;
   logic [AW-1:0]     mem_addr;
   logic [CELL_W-1:0] mem_wdata;
   logic              mem_we;
   logic              mem_re;

   logic [THR_W-1:0]  thr_ff;
   logic [AW-1:0]     clr_cnt_ff;
   logic [AW-1:0]     act_addr_ff, act_addr_in;
   logic [AW-1:0]     pas_addr_ff, pas_addr_in;
   logic              infect_ff, infect_in;
   logic [CELL_W-1:0] act_cell_ff;
   logic [CNT_W-1:0]  sus_ff, sus_in;
   logic [CNT_W-1:0]  inf_ff, inf_in;
   logic [CNT_W-1:0]  rec_ff, rec_in;
   logic [CHG_W-1:0]  chg_in;
   rsp_payload_type   rsp_ff;

   logic [RW-1:0]     r_sel, nr_sel;
   logic [CW-1:0]     c_sel, nc_sel;
   logic              infect_go, recover_go;

   assign status.clear_last = (clr_cnt_ff == LAST);

   always_comb begin
      r_sel  = row_mod[req_data.row];
      c_sel  = col_mod[req_data.col];
      nr_sel = r_sel;
      nc_sel = c_sel;
      case (req_data.direction)
         DIR_ROW_INC: nr_sel = (r_sel == RW'(ROWS - 1)) ? '0 : r_sel + RW'(1);
         DIR_ROW_DEC: nr_sel = (r_sel == '0) ? RW'(ROWS - 1) : r_sel - RW'(1);
         DIR_COL_INC: nc_sel = (c_sel == CW'(COLS - 1)) ? '0 : c_sel + CW'(1);
         default:     nc_sel = (c_sel == '0) ? CW'(COLS - 1) : c_sel - CW'(1);
      endcase
      act_addr_in = AW'(r_sel) * AW'(COLS) + AW'(c_sel);
      pas_addr_in = AW'(nr_sel) * AW'(COLS) + AW'(nc_sel);
      infect_in   = {1'b0, req_data.action_draw} < thr_ff;
   end

   // decision on the chosen cell and the neighbor just read
   assign infect_go  = infect_ff && (act_cell_ff == CELL_INF) && (mem_rd_ff == CELL_SUS);
   assign recover_go = !infect_ff && (act_cell_ff == CELL_INF);

   always_comb begin
      sus_in = sus_ff;
      inf_in = inf_ff;
      rec_in = rec_ff;
      chg_in = CHG_NONE;
      if (infect_go) begin
         sus_in = sus_ff - CNT_W'(1);
         inf_in = inf_ff + CNT_W'(1);
         chg_in = CHG_INFECT;
      end else if (recover_go) begin
         inf_in = inf_ff - CNT_W'(1);
         rec_in = rec_ff + CNT_W'(1);
         chg_in = CHG_RECOVER;
      end
   end

   // single memory port: clearing write, two reads, one write-back
   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = act_addr_ff;
      mem_wdata = CELL_REC;
      if (cmd.clear) begin
         mem_we    = 1'b1;
         mem_addr  = clr_cnt_ff;
         mem_wdata = (clr_cnt_ff == CENTRE) ? CELL_INF : CELL_SUS;
      end else if (cmd.rd_act) begin
         mem_re = 1'b1;
      end else if (cmd.rd_pas) begin
         mem_re   = 1'b1;
         mem_addr = pas_addr_ff;
      end else if (cmd.exec && infect_go) begin
         mem_we    = 1'b1;
         mem_addr  = pas_addr_ff;
         mem_wdata = CELL_INF;
      end else if (cmd.exec && recover_go) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) lattice_ff[mem_addr] <= mem_wdata;
      else if (mem_re) mem_rd_ff <= lattice_ff[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= THR_RESET;
         clr_cnt_ff <= '0;
         sus_ff     <= CNT_W'(DEPTH - 1);
         inf_ff     <= CNT_W'(1);
         rec_ff     <= '0;
      end else begin
         if (csr_wr_en) thr_ff <= csr_wr_data;
         if (cmd.clear && !status.clear_last) clr_cnt_ff <= clr_cnt_ff + AW'(1);
         if (cmd.exec) begin
            sus_ff <= sus_in;
            inf_ff <= inf_in;
            rec_ff <= rec_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_addr_ff <= act_addr_in;
         pas_addr_ff <= pas_addr_in;
         infect_ff   <= infect_in;
      end
      if (cmd.cap_act) act_cell_ff <= mem_rd_ff;
      if (cmd.exec) begin
         rsp_ff.susceptible_count <= COUNT_W'(sus_in);
         rsp_ff.infected_count    <= COUNT_W'(inf_in);
         rsp_ff.recovered_count   <= COUNT_W'(rec_in);
         rsp_ff.cell_changed      <= chg_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: design/sir_lattice_monte_carlo_update_core.sv
// Top level of the SIR lattice update core: sequencer plus datapath.
// Depends on sirl_pkg, sirl_req_if, sirl_rsp_if, sirl_ctrl, sirl_dpath.
//
//   channel   direction  handshake     contents
//   req_if    in         valid/ready   row, col, direction, action_draw
//   rsp_if    out        valid/ready   three class counts, cell_changed
//   csr_*     in         write enable  infection_threshold (17 bits)
//
// A trial runs through accept, read of the chosen cell and read of the
// neighbor in order, then an execute step that writes back and overlaps the next
// accept; the single lattice memory port sets this order.
// After reset a clearing pass rewrites every cell of the lattice
// (centre cell infected); req_if.ready stays low during it.
// A stalled result holds in the output register; the next trial may be
// accepted and read meanwhile, and waits in execute until the register frees.
module sir_lattice_monte_carlo_update_core #(
   parameter int ROWS = sirl_pkg::ROWS_DEFAULT,
   parameter int COLS = sirl_pkg::COLS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   sirl_req_if.sink                   req_if,
   sirl_rsp_if.source                 rsp_if,
   input  logic                       csr_wr_en,
   input  logic [sirl_pkg::THR_W-1:0] csr_wr_data
);
   import sirl_pkg::*;

   ctrl_cmd_type    cmd;
   dp_status_type   status;
   req_payload_type req_data;
   rsp_payload_type rsp_data;

   // gather the request fields into one transaction word
   assign req_data.row         = req_if.row;
   assign req_data.col         = req_if.col;
   assign req_data.direction   = req_if.direction;
   assign req_data.action_draw = req_if.action_draw;

   sirl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sirl_dpath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // drive the result channel from the output register
   assign rsp_if.susceptible_count = rsp_data.susceptible_count;
   assign rsp_if.infected_count    = rsp_data.infected_count;
   assign rsp_if.recovered_count   = rsp_data.recovered_count;
   assign rsp_if.cell_changed      = rsp_data.cell_changed;

endmodule

FILE: design/sirl_checker.sv
// Port-level checker for the SIR lattice update core, with its bind.
// Depends on sirl_pkg and sir_lattice_monte_carlo_update_core_macros.svh.
`include "sir_lattice_monte_carlo_update_core_macros.svh"

module sirl_checker #(
   parameter int ROWS = sirl_pkg::ROWS_DEFAULT,
   parameter int COLS = sirl_pkg::COLS_DEFAULT
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [sirl_pkg::COUNT_W-1:0] sus_count,
   input logic [sirl_pkg::COUNT_W-1:0] inf_count,
   input logic [sirl_pkg::COUNT_W-1:0] rec_count,
   input logic [sirl_pkg::CHG_W-1:0]   changed
);
   import sirl_pkg::*;

   localparam logic [COUNT_W-1:0] TOTAL = COUNT_W'(ROWS * COLS);

   logic [COUNT_W-1:0] sum_w;
   logic               chg_legal;
   assign sum_w     = sus_count + inf_count + rec_count;
   assign chg_legal = (changed == CHG_NONE) || (changed == CHG_INFECT) ||
                      (changed == CHG_RECOVER);

   // no trial is taken as the clearing pass starts after reset
   `SIRL_ASSERT_NEXT_ALWAYS(a_clear_blocks_req, clock, reset, !req_ready)
   // hold a stalled result
   `SIRL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // every cell is in exactly one class
   `SIRL_ASSERT_SAME(a_count_total, clock, reset, rsp_valid, sum_w == TOTAL)
   `SIRL_ASSERT_SAME(a_change_code, clock, reset, rsp_valid, chg_legal)

endmodule

bind sir_lattice_monte_carlo_update_core sirl_checker #(
   .ROWS (ROWS),
   .COLS (COLS)
) u_sirl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .sus_count (rsp_if.susceptible_count),
   .inf_count (rsp_if.infected_count),
   .rec_count (rsp_if.recovered_count),
   .changed   (rsp_if.cell_changed)
);
